FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL; every check is clocked on i_clk
// and held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check
`define FWUS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check
`define FWUS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/fwus_pkg.sv
package fwus_pkg;

    // fixed field widths
    localparam int REQ_TYPE_W = 2;
    localparam int COORD_W    = 16;
    localparam int CLIP_W     = 18;
    localparam int STATUS_W   = 3;
    localparam int WIN_W      = 8;
    localparam int ADDR_OUT_W = 17;
    localparam int LEN_W      = 16;

    // chunk limit register
    localparam logic [LEN_W-1:0] LIMIT_RESET = 16'd30000;
    localparam logic [LEN_W-1:0] LIMIT_MIN   = 16'd2;

    // request codes
    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_FULL = 2'd0,
        REQ_RECT = 2'd1,
        REQ_DONE = 2'd2
    } t_req;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_STARTED  = 3'd0,
        ST_QUEUED   = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_NEXT     = 3'd3,
        ST_FINISHED = 3'd4,
        ST_IGNORED  = 3'd5
    } t_status;

    // pending slot contents
    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_FULL = 2'd1,
        PEND_RECT = 2'd2
    } t_pend;

endpackage

FILE: hdl/fwus_cfg_if.sv
interface fwus_cfg_if;
    import fwus_pkg::*;

    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] chunk_limit;

    modport source (output valid, output chunk_limit, input ready);
    modport sink   (input valid, input chunk_limit, output ready);
endinterface

FILE: hdl/fwus_req_if.sv
interface fwus_req_if;
    import fwus_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [REQ_TYPE_W-1:0]     req_type;
    logic signed [COORD_W-1:0] rect_x;
    logic signed [COORD_W-1:0] rect_y;
    logic signed [COORD_W-1:0] rect_w;
    logic signed [COORD_W-1:0] rect_h;

    modport source (output valid, output req_type, output rect_x, output rect_y,
                    output rect_w, output rect_h, input ready);
    modport sink   (input valid, input req_type, input rect_x, input rect_y,
                    input rect_w, input rect_h, output ready);
endinterface

FILE: hdl/fwus_rsp_if.sv
interface fwus_rsp_if;
    import fwus_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   event_status;
    logic                  window_valid;
    logic [WIN_W-1:0]      win_x0;
    logic [WIN_W-1:0]      win_y0;
    logic [WIN_W-1:0]      win_x1;
    logic [WIN_W-1:0]      win_y1;
    logic                  chunk_valid;
    logic [ADDR_OUT_W-1:0] chunk_addr;
    logic [LEN_W-1:0]      chunk_len;

    modport source (output valid, output event_status, output window_valid,
                    output win_x0, output win_y0, output win_x1, output win_y1,
                    output chunk_valid, output chunk_addr, output chunk_len,
                    input ready);
    modport sink   (input valid, input event_status, input window_valid,
                    input win_x0, input win_y0, input win_x1, input win_y1,
                    input chunk_valid, input chunk_addr, input chunk_len,
                    output ready);
endinterface

FILE: hdl/framebuffer_window_update_sequencer.sv
// Channel   Dir  Beat contents
// i_cfg     in   chunk_limit (largest chunk in bytes)
// i_req     in   req_type, rect_x, rect_y, rect_w, rect_h
// o_rsp     out  event_status, window, chunk address and length
//
// One beat per cycle while o_rsp.ready is high; each beat passes the input register, then
// the result register, with the single clip/address pass between them.
// Synchronous active-low reset: idle, nothing pending, chunk limit 30000.
// With o_rsp.ready low the result register holds and one more beat waits in
// the input register; i_req.ready drops only when both are full.
// i_cfg is always ready.
module framebuffer_window_update_sequencer #(
    parameter int PANEL_WIDTH  = 240,
    parameter int PANEL_HEIGHT = 240
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fwus_cfg_if.sink          i_cfg,
    fwus_req_if.sink          i_req,
    fwus_rsp_if.source        o_rsp
);
    import fwus_pkg::*;

    localparam int TOTAL_BYTES = PANEL_WIDTH * PANEL_HEIGHT * 2;
    localparam int OFS_W  = $clog2(TOTAL_BYTES + 1);
    localparam int XW     = $clog2(PANEL_WIDTH + 1);
    localparam int YW     = $clog2(PANEL_HEIGHT + 1);
    localparam int RW     = $clog2(2 * PANEL_WIDTH + 1);
    localparam int ADDR_W = OFS_W + 1;
    localparam int FCMP_W = (OFS_W > LEN_W) ? OFS_W : LEN_W;
    localparam int RCMP_W = (RW > LEN_W) ? RW : LEN_W;
    localparam logic [OFS_W-1:0] TOTAL_V = OFS_W'(TOTAL_BYTES);
    localparam logic signed [CLIP_W-1:0] PW_S = CLIP_W'(PANEL_WIDTH);
    localparam logic signed [CLIP_W-1:0] PH_S = CLIP_W'(PANEL_HEIGHT);
    localparam logic [WIN_W-1:0] FULL_X1 = WIN_W'(PANEL_WIDTH - 1);
    localparam logic [WIN_W-1:0] FULL_Y1 = WIN_W'(PANEL_HEIGHT - 1);

    // handshake and stage registers
    logic                      r_s1_valid;
    logic [REQ_TYPE_W-1:0]     r_s1_type;
    logic signed [COORD_W-1:0] r_s1_x, r_s1_y, r_s1_w, r_s1_h;
    logic                      r_out_valid;
    logic                      out_adv, s1_fire;

    // sequencer state
    logic [LEN_W-1:0] r_limit;
    logic             r_busy, r_rect_mode;
    logic [OFS_W-1:0] r_full_ofs;
    logic [XW-1:0]    r_ax, r_aw, r_px, r_pw;
    logic [YW-1:0]    r_ay, r_ah, r_py, r_ph, r_row;
    logic [RW-1:0]    r_rbo;
    t_pend            r_pend_kind;

    // result registers
    t_status               r_o_status;
    logic                  r_o_win_v, r_o_chunk_v;
    logic [WIN_W-1:0]      r_o_x0, r_o_y0, r_o_x1, r_o_y1;
    logic [ADDR_OUT_W-1:0] r_o_addr;
    logic [LEN_W-1:0]      r_o_len;

    // handshakes: result register parts the two sides
    assign out_adv     = !r_out_valid || o_rsp.ready;
    assign s1_fire     = r_s1_valid && out_adv;
    assign i_req.ready = !r_s1_valid || out_adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_limit     <= LIMIT_RESET;
        end else begin
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_limit <= i_cfg.chunk_limit;
            end
        end
    end

    // input payload register
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_s1_type <= i_req.req_type;
            r_s1_x    <= i_req.rect_x;
            r_s1_y    <= i_req.rect_y;
            r_s1_w    <= i_req.rect_w;
            r_s1_h    <= i_req.rect_h;
        end
    end

    // rectangle clipping in wide signed arithmetic
    logic signed [CLIP_W-1:0] sx, sy, sw, sh, x1, y1, w1, h1, w2, h2;
    logic                     c_ok;
    logic [XW-1:0]            c_x, c_w;
    logic [YW-1:0]            c_y, c_h;

    assign sx = {{(CLIP_W-COORD_W){r_s1_x[COORD_W-1]}}, r_s1_x};
    assign sy = {{(CLIP_W-COORD_W){r_s1_y[COORD_W-1]}}, r_s1_y};
    assign sw = {{(CLIP_W-COORD_W){r_s1_w[COORD_W-1]}}, r_s1_w};
    assign sh = {{(CLIP_W-COORD_W){r_s1_h[COORD_W-1]}}, r_s1_h};
    assign x1 = sx[CLIP_W-1] ? '0 : sx;
    assign y1 = sy[CLIP_W-1] ? '0 : sy;
    assign w1 = sx[CLIP_W-1] ? sw + sx : sw;
    assign h1 = sy[CLIP_W-1] ? sh + sy : sh;
    assign w2 = (x1 + w1 > PW_S) ? PW_S - x1 : w1;
    assign h2 = (y1 + h1 > PH_S) ? PH_S - y1 : h1;
    assign c_ok = (sw > 0) && (sh > 0) && (sx < PW_S) && (sy < PH_S)
                  && (w1 > 0) && (h1 > 0) && (w2 > 0) && (h2 > 0);
    assign c_x = XW'(x1);
    assign c_y = YW'(y1);
    assign c_w = XW'(w2);
    assign c_h = YW'(h2);

    // event decode
    t_status       d_status;
    t_pend         d_pend;
    logic          d_busy, d_pend_load, d_finish;
    logic          d_start_full, d_start_rect, d_next_full, d_next_rect;
    logic [XW-1:0] g_x, g_w;
    logic [YW-1:0] g_y, g_h;

    always_comb begin
        d_status     = ST_IGNORED;
        d_pend       = r_pend_kind;
        d_busy       = r_busy;
        d_pend_load  = 1'b0;
        d_finish     = 1'b0;
        d_start_full = 1'b0;
        d_start_rect = 1'b0;
        d_next_full  = 1'b0;
        d_next_rect  = 1'b0;
        g_x = c_x;
        g_y = c_y;
        g_w = c_w;
        g_h = c_h;
        case (t_req'(r_s1_type))
            REQ_FULL: begin
                if (r_busy) begin
                    d_pend   = PEND_FULL;
                    d_status = ST_QUEUED;
                end else begin
                    d_start_full = 1'b1;
                end
            end
            REQ_RECT: begin
                if (!c_ok) begin
                    d_status = ST_DROPPED;
                end else if (r_busy) begin
                    d_pend      = PEND_RECT;
                    d_pend_load = 1'b1;
                    d_status    = ST_QUEUED;
                end else begin
                    d_start_rect = 1'b1;
                end
            end
            REQ_DONE: begin
                if (r_busy) begin
                    if (!r_rect_mode) begin
                        if (r_full_ofs >= TOTAL_V) begin
                            d_finish = 1'b1;
                        end else begin
                            d_status    = ST_NEXT;
                            d_next_full = 1'b1;
                        end
                    end else begin
                        if (r_row >= r_ah) begin
                            d_finish = 1'b1;
                        end else begin
                            d_status    = ST_NEXT;
                            d_next_rect = 1'b1;
                        end
                    end
                end
            end
            default: begin
                d_status = ST_IGNORED;
            end
        endcase
        // finish: launch whatever waits in the pending slot
        if (d_finish) begin
            d_busy = 1'b0;
            d_pend = PEND_NONE;
            case (r_pend_kind)
                PEND_FULL: begin
                    d_start_full = 1'b1;
                end
                PEND_RECT: begin
                    d_start_rect = 1'b1;
                    g_x = r_px;
                    g_y = r_py;
                    g_w = r_pw;
                    g_h = r_ph;
                end
                default: begin
                    d_status = ST_FINISHED;
                end
            endcase
        end
        if (d_start_full || d_start_rect) begin
            d_busy   = 1'b1;
            d_status = ST_STARTED;
        end
    end

    // chunk sizing and addressing
    logic [LEN_W-1:0]  lim_e;
    logic [OFS_W-1:0]  full_base, full_remain, full_next;
    logic [LEN_W-1:0]  full_len;
    logic [XW-1:0]     b_x, b_w;
    logic [YW-1:0]     b_y, b_row;
    logic [RW-1:0]     b_rbo, rect_total, rect_remain, rect_sum;
    logic [LEN_W-1:0]  rect_len;
    logic [YW:0]       rect_line;
    logic [ADDR_W-1:0] rect_addr;
    logic [XW:0]       win_xe;
    logic [YW:0]       win_ye;

    assign lim_e = (r_limit < LIMIT_MIN) ? LIMIT_MIN : r_limit;

    assign full_base   = d_start_full ? '0 : r_full_ofs;
    assign full_remain = TOTAL_V - full_base;
    assign full_len    = (FCMP_W'(full_remain) > FCMP_W'(lim_e)) ? lim_e
                                                                  : LEN_W'(full_remain);
    assign full_next   = full_base + OFS_W'(full_len);

    assign b_x   = d_start_rect ? g_x : r_ax;
    assign b_y   = d_start_rect ? g_y : r_ay;
    assign b_w   = d_start_rect ? g_w : r_aw;
    assign b_row = d_start_rect ? '0 : r_row;
    assign b_rbo = d_start_rect ? '0 : r_rbo;

    assign rect_total  = RW'({b_w, 1'b0});
    assign rect_remain = rect_total - b_rbo;
    assign rect_len    = (RCMP_W'(rect_remain) > RCMP_W'(lim_e)) ? lim_e
                                                                 : LEN_W'(rect_remain);
    assign rect_sum    = b_rbo + RW'(rect_len);
    assign rect_line   = (YW+1)'(b_y) + (YW+1)'(b_row);
    assign rect_addr   = ((ADDR_W'(rect_line) * ADDR_W'(PANEL_WIDTH) + ADDR_W'(b_x)) << 1)
                         + ADDR_W'(b_rbo);

    assign win_xe = (XW+1)'(g_x) + (XW+1)'(g_w) - 1'b1;
    assign win_ye = (YW+1)'(g_y) + (YW+1)'(g_h) - 1'b1;

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_rect_mode <= 1'b0;
            r_full_ofs  <= '0;
            r_ax        <= '0;
            r_ay        <= '0;
            r_aw        <= '0;
            r_ah        <= '0;
            r_row       <= '0;
            r_rbo       <= '0;
            r_pend_kind <= PEND_NONE;
            r_px        <= '0;
            r_py        <= '0;
            r_pw        <= '0;
            r_ph        <= '0;
        end else if (s1_fire) begin
            r_busy      <= d_busy;
            r_pend_kind <= d_pend;
            if (d_start_full) begin
                r_rect_mode <= 1'b0;
            end
            if (d_start_rect) begin
                r_rect_mode <= 1'b1;
                r_ax        <= g_x;
                r_ay        <= g_y;
                r_aw        <= g_w;
                r_ah        <= g_h;
            end
            if (d_start_full || d_next_full) begin
                r_full_ofs <= full_next;
            end
            if (d_start_rect || d_next_rect) begin
                if (rect_sum >= rect_total) begin
                    r_row <= b_row + 1'b1;
                    r_rbo <= '0;
                end else begin
                    r_row <= b_row;
                    r_rbo <= rect_sum;
                end
            end
            if (d_pend_load) begin
                r_px <= c_x;
                r_py <= c_y;
                r_pw <= c_w;
                r_ph <= c_h;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_o_status  <= d_status;
            r_o_win_v   <= d_start_full || d_start_rect;
            r_o_chunk_v <= d_start_full || d_start_rect || d_next_full || d_next_rect;
            if (d_start_full) begin
                r_o_x0 <= '0;
                r_o_y0 <= '0;
                r_o_x1 <= FULL_X1;
                r_o_y1 <= FULL_Y1;
            end else if (d_start_rect) begin
                r_o_x0 <= WIN_W'(g_x);
                r_o_y0 <= WIN_W'(g_y);
                r_o_x1 <= WIN_W'(win_xe);
                r_o_y1 <= WIN_W'(win_ye);
            end else begin
                r_o_x0 <= '0;
                r_o_y0 <= '0;
                r_o_x1 <= '0;
                r_o_y1 <= '0;
            end
            if (d_start_full || d_next_full) begin
                r_o_addr <= ADDR_OUT_W'(full_base);
                r_o_len  <= full_len;
            end else if (d_start_rect || d_next_rect) begin
                r_o_addr <= ADDR_OUT_W'(rect_addr);
                r_o_len  <= rect_len;
            end else begin
                r_o_addr <= '0;
                r_o_len  <= '0;
            end
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.event_status = r_o_status;
    assign o_rsp.window_valid = r_o_win_v;
    assign o_rsp.win_x0       = r_o_x0;
    assign o_rsp.win_y0       = r_o_y0;
    assign o_rsp.win_x1       = r_o_x1;
    assign o_rsp.win_y1       = r_o_y1;
    assign o_rsp.chunk_valid  = r_o_chunk_v;
    assign o_rsp.chunk_addr   = r_o_addr;
    assign o_rsp.chunk_len    = r_o_len;

    // checks
`include "assert_macros.svh"
    `FWUS_ASSERT_IMP(a_pend_needs_busy, r_pend_kind != PEND_NONE, r_busy, "pending request while idle")
    `FWUS_ASSERT_IMP(a_win_has_chunk, r_out_valid && r_o_win_v, r_o_chunk_v, "window without first chunk")
    `FWUS_ASSERT_IMP(a_chunk_nonzero, r_out_valid && r_o_chunk_v, r_o_len != '0, "empty chunk issued")
    `FWUS_ASSERT_NXT(a_s1_drains, r_s1_valid && !r_out_valid, r_out_valid, "input beat did not move")

endmodule

FILE: sim/framebuffer_window_update_sequencer_tb.sv
`timescale 1ns / 100ps

module framebuffer_window_update_sequencer_tb;
    import fwus_pkg::*;

    localparam int PANEL_W         = 240;
    localparam int PANEL_H         = 240;
    localparam int FRAME_BYTES     = PANEL_W * PANEL_H * 2;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER  = 300;
    localparam int QUIET_LIMIT     = 3000;

    // request code outside the defined set; the block must ignore it
    localparam logic [REQ_TYPE_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef struct {
        logic [REQ_TYPE_W-1:0]     kind;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] w;
        logic signed [COORD_W-1:0] h;
    } t_req_beat;

    typedef struct {
        t_status               status;
        logic                  win_v;
        logic [WIN_W-1:0]      x0;
        logic [WIN_W-1:0]      y0;
        logic [WIN_W-1:0]      x1;
        logic [WIN_W-1:0]      y1;
        logic                  chunk_v;
        logic [ADDR_OUT_W-1:0] addr;
        logic [LEN_W-1:0]      len;
    } t_rsp_beat;

    // Window/chunk predictor plus in-order result checker
    class window_chunk_scoreboard;
        logic [LEN_W-1:0]      limit;
        bit                    busy;
        bit                    rect_mode;
        logic [ADDR_OUT_W-1:0] full_off;
        logic [7:0]            ax, ay, aw, ah;
        logic [7:0]            row_idx;
        logic [8:0]            row_off;
        t_pend                 pend_kind;
        logic [7:0]            px, py, pw, ph;
        t_rsp_beat             expected_q[$];
        int                    errors;
        int                    requests_noted;
        int                    results_checked;
        int                    status_seen[6];

        function new();
            limit     = LIMIT_RESET;
            busy      = 0;
            rect_mode = 0;
            full_off  = '0;
            ax = '0; ay = '0; aw = '0; ah = '0;
            row_idx   = '0;
            row_off   = '0;
            pend_kind = PEND_NONE;
            px = '0; py = '0; pw = '0; ph = '0;
            errors          = 0;
            requests_noted  = 0;
            results_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_limit(logic [LEN_W-1:0] v);
            limit = v;
        endfunction

        function int eff_limit();
            return (limit < LIMIT_MIN) ? int'(LIMIT_MIN) : int'(limit);
        endfunction

        // next chunk of a full-frame update
        function void full_chunk(inout t_rsp_beat e);
            int remain, len;
            remain    = FRAME_BYTES - int'(full_off);
            len       = (remain > eff_limit()) ? eff_limit() : remain;
            e.chunk_v = 1;
            e.addr    = full_off;
            e.len     = len[LEN_W-1:0];
            full_off  = full_off + len[ADDR_OUT_W-1:0];
        endfunction

        // next chunk of the current rectangle row
        function void rect_chunk(inout t_rsp_beat e);
            int row_total, remain, len, addr;
            row_total = 2 * int'(aw);
            remain    = row_total - int'(row_off);
            len       = (remain > eff_limit()) ? eff_limit() : remain;
            addr      = ((int'(ay) + int'(row_idx)) * PANEL_W + int'(ax)) * 2 + int'(row_off);
            e.chunk_v = 1;
            e.addr    = addr[ADDR_OUT_W-1:0];
            e.len     = len[LEN_W-1:0];
            row_off   = row_off + len[8:0];
            if (int'(row_off) >= row_total) begin
                row_idx = row_idx + 8'd1;
                row_off = '0;
            end
        endfunction

        function void start_full(inout t_rsp_beat e);
            busy      = 1;
            rect_mode = 0;
            full_off  = '0;
            e.status  = ST_STARTED;
            e.win_v   = 1;
            e.x0 = '0; e.y0 = '0;
            e.x1 = 8'(PANEL_W - 1); e.y1 = 8'(PANEL_H - 1);
            full_chunk(e);
        endfunction

        function void start_rect(inout t_rsp_beat e, input int x, int y, int w, int h);
            busy      = 1;
            rect_mode = 1;
            ax = x[7:0]; ay = y[7:0]; aw = w[7:0]; ah = h[7:0];
            row_idx   = '0;
            row_off   = '0;
            e.status  = ST_STARTED;
            e.win_v   = 1;
            e.x0 = 8'(x); e.y0 = 8'(y);
            e.x1 = 8'(x + w - 1); e.y1 = 8'(y + h - 1);
            rect_chunk(e);
        endfunction

        // end of transfer: launch whatever waits in the pending slot
        function void close_transfer(inout t_rsp_beat e);
            t_pend k;
            k         = pend_kind;
            busy      = 0;
            pend_kind = PEND_NONE;
            if (k == PEND_FULL)
                start_full(e);
            else if (k == PEND_RECT)
                start_rect(e, int'(px), int'(py), int'(pw), int'(ph));
            else
                e.status = ST_FINISHED;
        endfunction

        function void note_request(t_req_beat rq);
            t_rsp_beat e;
            int        x, y, w, h;
            bit        ok;
            e.status  = ST_IGNORED;
            e.win_v   = 0;
            e.x0 = '0; e.y0 = '0; e.x1 = '0; e.y1 = '0;
            e.chunk_v = 0;
            e.addr    = '0;
            e.len     = '0;
            requests_noted++;
            if (rq.kind == REQ_FULL) begin
                if (busy) begin
                    pend_kind = PEND_FULL;
                    e.status  = ST_QUEUED;
                end else begin
                    start_full(e);
                end
            end else if (rq.kind == REQ_RECT) begin
                x = rq.x; y = rq.y; w = rq.w; h = rq.h;
                // clip to the panel in 32-bit signed math
                ok = (w > 0) && (h > 0) && (x < PANEL_W) && (y < PANEL_H);
                if (ok) begin
                    if (x < 0) begin
                        w = w + x;
                        x = 0;
                    end
                    if (y < 0) begin
                        h = h + y;
                        y = 0;
                    end
                    ok = (w > 0) && (h > 0);
                end
                if (ok) begin
                    if (x + w > PANEL_W) w = PANEL_W - x;
                    if (y + h > PANEL_H) h = PANEL_H - y;
                    ok = (w > 0) && (h > 0);
                end
                if (!ok) begin
                    e.status = ST_DROPPED;
                end else if (busy) begin
                    pend_kind = PEND_RECT;
                    px = x[7:0]; py = y[7:0]; pw = w[7:0]; ph = h[7:0];
                    e.status  = ST_QUEUED;
                end else begin
                    start_rect(e, x, y, w, h);
                end
            end else if (rq.kind == REQ_DONE && busy) begin
                if (!rect_mode) begin
                    if (int'(full_off) >= FRAME_BYTES) begin
                        close_transfer(e);
                    end else begin
                        e.status = ST_NEXT;
                        full_chunk(e);
                    end
                end else begin
                    if (row_idx >= ah) begin
                        close_transfer(e);
                    end else begin
                        e.status = ST_NEXT;
                        rect_chunk(e);
                    end
                end
            end
            expected_q.push_back(e);
        endfunction

        function void cmp(string name, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v) begin
                $error("%s: expected %0d, got %0d", name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(t_rsp_beat got);
            t_rsp_beat want;
            if (expected_q.size() == 0) begin
                $error("result beat with no request outstanding (status %0d)", got.status);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            status_seen[want.status]++;
            cmp("event_status", 32'(want.status), 32'(got.status));
            cmp("window_valid", 32'(want.win_v), 32'(got.win_v));
            cmp("win_x0", 32'(want.x0), 32'(got.x0));
            cmp("win_y0", 32'(want.y0), 32'(got.y0));
            cmp("win_x1", 32'(want.x1), 32'(got.x1));
            cmp("win_y1", 32'(want.y1), 32'(got.y1));
            cmp("chunk_valid", 32'(want.chunk_v), 32'(got.chunk_v));
            cmp("chunk_addr", 32'(want.addr), 32'(got.addr));
            cmp("chunk_len", 32'(want.len), 32'(got.len));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    fwus_cfg_if cfg_if ();
    fwus_req_if req_if ();
    fwus_rsp_if rsp_if ();

    framebuffer_window_update_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    window_chunk_scoreboard sb;

    // stimulus shaping for the current chunk limit
    bit full_ok;
    bit rows_big_ok;
    bit tiny_rows;
    int settings_run;

    logic any_beat;
    assign any_beat = (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                   || (cfg_if.valid && cfg_if.ready);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // sample all three channels at the rising edge
    always @(posedge i_clk) begin : monitor
        t_rsp_beat got;
        t_req_beat rq;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                sb.set_limit(cfg_if.chunk_limit);
            if (rsp_if.valid && rsp_if.ready) begin
                got.status  = t_status'(rsp_if.event_status);
                got.win_v   = rsp_if.window_valid;
                got.x0      = rsp_if.win_x0;
                got.y0      = rsp_if.win_y0;
                got.x1      = rsp_if.win_x1;
                got.y1      = rsp_if.win_y1;
                got.chunk_v = rsp_if.chunk_valid;
                got.addr    = rsp_if.chunk_addr;
                got.len     = rsp_if.chunk_len;
                sb.check_result(got);
            end
            if (req_if.valid && req_if.ready) begin
                rq.kind = req_if.req_type;
                rq.x    = req_if.rect_x;
                rq.y    = req_if.rect_y;
                rq.w    = req_if.rect_w;
                rq.h    = req_if.rect_h;
                sb.note_request(rq);
            end
        end
    end

    // watchdog: too long without any beat on any channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (any_beat)
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    // result side: random ready, plus one long hold-off to back up the block
    initial begin : result_sink
        int  r, len;
        bit  on, held;
        rsp_if.ready = 1'b0;
        held = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!held && sb.results_checked >= HOLD_OFF_AFTER) begin
                held = 1;
                @(negedge i_clk);
                rsp_if.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (r < 60) begin
                on = 1; len = $urandom_range(1, 40);
            end else if (r < 88) begin
                on = 0; len = $urandom_range(1, 3);
            end else if (r < 97) begin
                on = 0; len = $urandom_range(4, 12);
            end else begin
                on = 0; len = $urandom_range(20, 60);
            end
            repeat (len) begin
                @(negedge i_clk);
                rsp_if.ready = on;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_req_beat mk(logic [REQ_TYPE_W-1:0] k, int x, int y, int w, int h);
        t_req_beat rq;
        rq.kind = k;
        rq.x = x[15:0]; rq.y = y[15:0]; rq.w = w[15:0]; rq.h = h[15:0];
        return rq;
    endfunction

    // well-formed rectangle sized so the transfer stays short at this limit
    function automatic t_req_beat rand_rect();
        if (tiny_rows)
            return mk(REQ_RECT, int'($urandom_range(0, 243)) - 4,
                      int'($urandom_range(0, 243)) - 4,
                      $urandom_range(1, 8), $urandom_range(1, 3));
        if (!rows_big_ok)
            return mk(REQ_RECT, int'($urandom_range(0, 270)) - 20,
                      int'($urandom_range(0, 270)) - 20,
                      $urandom_range(1, 260), $urandom_range(1, 6));
        return mk(REQ_RECT, int'($urandom_range(0, 270)) - 20,
                  int'($urandom_range(0, 270)) - 20, $urandom_range(1, 260),
                  ($urandom_range(0, 99) < 5) ? $urandom_range(1, 260)
                                              : $urandom_range(1, 16));
    endfunction

    // next request, steered by the predicted sequencer state
    function automatic t_req_beat pick_item();
        t_req_beat rq;
        int        r, w;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            // raw noise on every field
            rq.kind = REQ_TYPE_W'($urandom_range(0, 3));
            rq.x = 16'($urandom()); rq.y = 16'($urandom());
            rq.w = 16'($urandom()); rq.h = 16'($urandom());
            if (rq.kind == REQ_FULL && !full_ok) rq.kind = REQ_DONE;
            if (rq.kind == REQ_RECT && !rows_big_ok) rq.kind = REQ_UNKNOWN;
        end else if (r < 13) begin
            // rectangles that clip to nothing
            w = $urandom_range(1, 300);
            case ($urandom_range(0, 3))
                0: rq = mk(REQ_RECT, 10, 10, -int'($urandom_range(0, 32768)), 4);
                1: rq = mk(REQ_RECT, 10, 10, 4, -int'($urandom_range(0, 32768)));
                2: rq = mk(REQ_RECT, $urandom_range(240, 32767), 0, w, 4);
                default: rq = mk(REQ_RECT, 5, -(w + int'($urandom_range(0, 100))), 4, w);
            endcase
        end else if (sb.busy) begin
            if (r < 83)
                rq = mk(REQ_DONE, 0, 0, 0, 0);
            else if (r < 94 || !full_ok)
                rq = rand_rect();
            else
                rq = mk(REQ_FULL, 0, 0, 0, 0);
        end else begin
            if (r < 20)
                rq = mk(REQ_DONE, 0, 0, 0, 0);
            else if (r < 40 && full_ok)
                rq = mk(REQ_FULL, 0, 0, 0, 0);
            else
                rq = rand_rect();
        end
        return rq;
    endfunction

    // ends at a falling edge; lowers valid only when idling
    task automatic hold_gap(input int g);
        @(negedge i_clk);
        if (g > 0) begin
            req_if.valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    // present one beat and wait for the handshake
    task automatic put_beat(input t_req_beat rq);
        req_if.req_type = rq.kind;
        req_if.rect_x   = rq.x;
        req_if.rect_y   = rq.y;
        req_if.rect_w   = rq.w;
        req_if.rect_h   = rq.h;
        req_if.valid    = 1'b1;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic run_random(input int n, input bit steady);
        repeat (n) begin
            hold_gap(steady ? 0 : pick_gap());
            put_beat(pick_item());
        end
    endtask

    // issue done beats until the sequencer goes idle
    task automatic run_out_transfer();
        forever begin
            hold_gap(pick_gap());
            if (!sb.busy) begin
                req_if.valid = 1'b0;
                break;
            end
            put_beat(mk(REQ_DONE, 0, 0, 0, 0));
        end
    endtask

    // let every outstanding result come back, then let the bench settle
    task automatic quiesce();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (sb.expected_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LEN_W-1:0] v);
        int eff;
        @(negedge i_clk);
        cfg_if.chunk_limit = v;
        cfg_if.valid       = 1'b1;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
        eff          = (v < LIMIT_MIN) ? int'(LIMIT_MIN) : int'(v);
        full_ok      = (eff >= 4096);
        rows_big_ok  = (eff >= 480);
        tiny_rows    = (eff < 64);
        settings_run++;
    endtask

    initial begin : stimulus
        t_req_beat   directed_q[$];
        logic [15:0] limits[10];
        sb = new();
        req_if.valid       = 1'b0;
        req_if.req_type    = '0;
        req_if.rect_x      = '0;
        req_if.rect_y      = '0;
        req_if.rect_w      = '0;
        req_if.rect_h      = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.chunk_limit = '0;
        full_ok      = 1;
        rows_big_ok  = 1;
        tiny_rows    = 0;
        settings_run = 1;

        // reset
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed beats at the reset limit
        directed_q.push_back(mk(REQ_DONE, 0, 0, 0, 0));               // done while idle
        directed_q.push_back(mk(REQ_UNKNOWN, -1, -1, -1, -1));        // unknown code
        directed_q.push_back(mk(REQ_FULL, 0, 0, 0, 0));
        directed_q.push_back(mk(REQ_FULL, 0, 0, 0, 0));               // queued
        directed_q.push_back(mk(REQ_RECT, 0, 0, 1, 1));               // replaces it
        repeat (4) directed_q.push_back(mk(REQ_DONE, 0, 0, 0, 0));    // last chunk, then start
        directed_q.push_back(mk(REQ_DONE, 0, 0, 0, 0));               // finish, none pending
        directed_q.push_back(mk(REQ_RECT, 3, 3, 0, 5));               // zero width
        directed_q.push_back(mk(REQ_RECT, 0, 0, 5, -32768));          // most negative height
        directed_q.push_back(mk(REQ_RECT, 239, 239, 1, 1));           // far corner
        directed_q.push_back(mk(REQ_RECT, 0, 0, 32767, 32767));       // queued
        directed_q.push_back(mk(REQ_RECT, -10, -5, 20, 8));           // replaces it
        directed_q.push_back(mk(REQ_RECT, 240, 0, 5, 5));             // off panel, busy
        directed_q.push_back(mk(REQ_RECT, 32767, -1, 32767, 32767));
        directed_q.push_back(mk(REQ_DONE, 0, 0, 0, 0));               // finish into clipped rect
        directed_q.push_back(mk(REQ_RECT, -32768, -32768, 32767, 32767)); // clips to empty
        directed_q.push_back(mk(REQ_RECT, 230, 235, 32767, 32767));   // queued, clipped
        repeat (3) directed_q.push_back(mk(REQ_DONE, 0, 0, 0, 0));
        directed_q.push_back(mk(REQ_RECT, -32768, 100, -32768, 4));
        foreach (directed_q[i]) begin
            hold_gap(pick_gap());
            put_beat(directed_q[i]);
        end
        run_random(ITEMS_PER_PHASE, 1'b0);

        // chunk limit sweep: extremes, below-minimum values, row-sized, random
        limits[0] = 16'd65534;
        limits[1] = 16'd65535;
        limits[2] = LIMIT_MIN;
        limits[3] = 16'd0;
        limits[4] = 16'd1;
        limits[5] = 16'd100;
        limits[6] = 16'd480;
        limits[7] = 16'($urandom_range(2, 65534));
        limits[8] = 16'($urandom_range(2, 65534));
        limits[9] = LIMIT_RESET;
        foreach (limits[i]) begin
            run_out_transfer();
            quiesce();
            write_limit(limits[i]);
            run_random(ITEMS_PER_PHASE, (i % 3) == 2);
        end

        quiesce();
        $display("Run covered %0d request beats and %0d result beats over %0d chunk limits",
                 sb.requests_noted, sb.results_checked, settings_run);
        $display("Statuses: started %0d, queued %0d, dropped %0d, next %0d, done %0d, ign %0d",
                 sb.status_seen[ST_STARTED], sb.status_seen[ST_QUEUED],
                 sb.status_seen[ST_DROPPED], sb.status_seen[ST_NEXT],
                 sb.status_seen[ST_FINISHED], sb.status_seen[ST_IGNORED]);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
